// ----- hw/rtl/kfd_pkg.sv -----
// kfd_pkg: shared constants and types for the kiss frame deframer
package kfd_pkg;

    // framing characters
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // register defaults and length field width
    localparam int unsigned LENGTH_BITS_DEFAULT   = 10;
    localparam int unsigned MAX_FRAME_LEN_RESET   = 500;
    localparam logic [7:0]  DATA_CONTROL_RESET    = 8'h00;

    // configuration register indexes
    typedef enum logic {
        CFG_MAX_FRAME_LEN     = 1'b0,
        CFG_DATA_CONTROL_VALUE = 1'b1
    } cfg_index_t;

    // end-of-frame status codes
    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_NONDATA = 2'd1,
        STATUS_LONG    = 2'd2
    } frame_status_t;

endpackage

// ----- hw/rtl/kiss_frame_deframer_unit.sv -----
// kiss_frame_deframer_unit: kiss deframer with registered input and result stages
//
//  channel   | direction | ports
//  ----------+-----------+-------------------------------------------------------
//  s_        | in        | s_valid, s_ready, s_rx_byte
//  m_        | out       | m_valid, m_ready, m_payload_byte, m_frame_end,
//            |           | m_frame_length, m_frame_status
//  cfg_      | in        | cfg_wr_en, cfg_wr_index, cfg_wr_data
//
// one transaction per clock sustained while the result channel is not stalled; an
// input byte passes through the input register, then is decoded into the result
// register, which presents it on m_ until it is taken.
// reset (synchronous, aresetn low) clears frame state, both stage valids and
// loads the register defaults. a stalled result register holds the input
// register, which then lowers s_ready until the result is taken.
module kiss_frame_deframer_unit #(
    parameter int unsigned LENGTH_BITS = kfd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_payload_byte,
    output logic                   m_frame_end,
    output logic [LENGTH_BITS-1:0] m_frame_length,
    output logic [1:0]             m_frame_status,
    // configuration port
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_index,
    input  logic [((LENGTH_BITS > 8) ? LENGTH_BITS : 8)-1:0] cfg_wr_data
);
    import kfd_pkg::*;

    localparam int unsigned CW = LENGTH_BITS + 1;

    // configuration registers
    logic [LENGTH_BITS-1:0] max_frame_len_reg;
    logic [7:0]             data_control_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // frame state
    logic                   escape_reg,   escape_next;
    logic [LENGTH_BITS-1:0] count_reg,    count_next;
    logic                   rejected_reg, rejected_next;
    logic                   skip_reg,     skip_next;

    // result stage
    logic                   m_valid_reg;
    logic [7:0]             m_byte_reg;
    logic                   m_end_reg;
    logic [LENGTH_BITS-1:0] m_length_reg;
    frame_status_t          m_status_reg;

    // decode outputs
    logic                   res_valid;
    logic [7:0]             res_byte;
    logic                   res_end;
    logic [LENGTH_BITS-1:0] res_length;
    frame_status_t          res_status;

    logic       advance;
    logic [7:0] dec_byte;
    logic       delim;
    logic       esc_start;
    logic [LENGTH_BITS-1:0] payload_cnt;

    // handshake
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign payload_cnt = (count_reg == '0) ? '0 : count_reg - LENGTH_BITS'(1);

    // escape decode and frame state update
    always_comb begin
        escape_next   = escape_reg;
        count_next    = count_reg;
        rejected_next = rejected_reg;
        skip_next     = skip_reg;
        res_valid     = 1'b0;
        res_byte      = 8'h00;
        res_end       = 1'b0;
        res_length    = '0;
        res_status    = STATUS_GOOD;
        dec_byte      = in_byte_reg;
        delim         = 1'b0;
        esc_start     = 1'b0;

        if (escape_reg) begin
            escape_next = 1'b0;
            if (in_byte_reg == TFESC) begin
                dec_byte = FESC;
            end else if (in_byte_reg == TFEND) begin
                dec_byte = FEND;
            end
        end else if (in_byte_reg == FEND) begin
            delim = 1'b1;
        end else if (in_byte_reg == FESC) begin
            escape_next = 1'b1;
            esc_start   = 1'b1;
        end

        if (esc_start) begin
            // escape prefix alone gives nothing
        end else if (delim) begin
            if (skip_reg) begin
                skip_next     = 1'b0;
                count_next    = '0;
                rejected_next = 1'b0;
            end else if (count_reg != '0) begin
                res_valid     = 1'b1;
                res_end       = 1'b1;
                res_length    = payload_cnt;
                res_status    = rejected_reg ? STATUS_NONDATA : STATUS_GOOD;
                count_next    = '0;
                rejected_next = 1'b0;
            end
        end else if (skip_reg) begin
            // dropping bytes of an over-long frame
        end else if ((CW'(count_reg) + CW'(1)) > CW'(max_frame_len_reg)) begin
            skip_next     = 1'b1;
            res_valid     = 1'b1;
            res_end       = 1'b1;
            res_length    = payload_cnt;
            res_status    = STATUS_LONG;
            count_next    = '0;
            rejected_next = 1'b0;
        end else if (count_reg == '0) begin
            // control byte
            rejected_next = (dec_byte != data_control_reg);
            count_next    = LENGTH_BITS'(1);
        end else begin
            count_next = count_reg + LENGTH_BITS'(1);
            if (!rejected_reg) begin
                res_valid = 1'b1;
                res_byte  = dec_byte;
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg <= LENGTH_BITS'(MAX_FRAME_LEN_RESET);
            data_control_reg  <= DATA_CONTROL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_MAX_FRAME_LEN:      max_frame_len_reg <= cfg_wr_data[LENGTH_BITS-1:0];
                CFG_DATA_CONTROL_VALUE: data_control_reg  <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg   <= 1'b0;
            count_reg    <= '0;
            rejected_reg <= 1'b0;
            skip_reg     <= 1'b0;
        end else if (advance) begin
            escape_reg   <= escape_next;
            count_reg    <= count_next;
            rejected_reg <= rejected_next;
            skip_reg     <= skip_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_byte_reg   <= res_byte;
            m_end_reg    <= res_end;
            m_length_reg <= res_length;
            m_status_reg <= res_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_byte = m_byte_reg;
    assign m_frame_end    = m_end_reg;
    assign m_frame_length = m_length_reg;
    assign m_frame_status = m_status_reg;

`ifndef SYNTHESIS
    // payload results carry no length or status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_end_reg) |-> (m_status_reg == STATUS_GOOD && m_length_reg == '0))
        else $error("payload result with end fields set");

    // skipping only happens with an empty frame count
    assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> (count_reg == '0 && !rejected_reg))
        else $error("skip state with frame count");

    // a rejected frame always has its control byte stored
    assert property (@(posedge aclk) disable iff (!aresetn)
        rejected_reg |-> (count_reg != '0))
        else $error("rejected frame without control byte");

    // an over-long result enters the skip state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid && res_status == STATUS_LONG) |=> skip_reg)
        else $error("too-long result without skip");
`endif

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for the kiss frame deframer unit
`timescale 1ns / 100ps

module tb_top;
    import kfd_pkg::*;

    localparam int unsigned LB = LENGTH_BITS_DEFAULT;
    localparam int unsigned CW = (LB > 8) ? LB : 8;
    localparam int STALL_LIMIT = 500;

    // one decoded result as the block should present it
    typedef struct {
        logic [7:0]    payload;
        logic          is_end;
        logic [LB-1:0] length;
        frame_status_t status;
    } deframe_result_t;

    // dut signals
    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [7:0]    s_rx_byte = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [7:0]    m_payload_byte;
    logic          m_frame_end;
    logic [LB-1:0] m_frame_length;
    logic [1:0]    m_frame_status;
    logic          cfg_wr_en = 1'b0;
    cfg_index_t    cfg_wr_index = CFG_MAX_FRAME_LEN;
    logic [CW-1:0] cfg_wr_data = '0;

    // stimulus and scoreboard
    logic [7:0]      link_bytes[$];
    deframe_result_t decoded_fifo[$];
    int  queued_count = 0;
    int  taken_count = 0;
    int  error_count = 0;
    int  stall_cycles = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;

    // predictor copy of registers and frame state
    logic [LB-1:0] cfg_max_len = LB'(MAX_FRAME_LEN_RESET);
    logic [7:0]    cfg_ctrl = DATA_CONTROL_RESET;
    logic          esc_pending = 1'b0;
    logic [LB-1:0] stored_cnt = '0;
    logic          rejected = 1'b0;
    logic          skipping = 1'b0;

    kiss_frame_deframer_unit #(.LENGTH_BITS(LB)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_length (m_frame_length),
        .m_frame_status (m_frame_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int draw_idle(input bit enabled);
        return enabled ? int'($urandom_range(0, 9)) : 0;
    endfunction

    // end-of-frame result, then the frame state starts over
    task automatic close_frame(input frame_status_t st);
        deframe_result_t r;
        r.payload = '0;
        r.is_end  = 1'b1;
        r.length  = (stored_cnt == 0) ? '0 : stored_cnt - 1'b1;
        r.status  = st;
        decoded_fifo.push_back(r);
        stored_cnt = '0;
        rejected   = 1'b0;
    endtask

    // predicted effect of one received link byte
    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0]      c;
        logic            is_delim;
        deframe_result_t r;
        c = raw;
        is_delim = 1'b0;
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (c == TFESC) c = FESC;
            else if (c == TFEND) c = FEND;
        end else if (c == FEND) begin
            is_delim = 1'b1;
        end else if (c == FESC) begin
            esc_pending = 1'b1;
            return;
        end
        if (is_delim) begin
            if (skipping) begin
                skipping   = 1'b0;
                stored_cnt = '0;
                rejected   = 1'b0;
            end else if (stored_cnt != 0) begin
                close_frame(rejected ? STATUS_NONDATA : STATUS_GOOD);
            end
        end else if (!skipping) begin
            if (int'(stored_cnt) + 1 > int'(cfg_max_len)) begin
                skipping = 1'b1;
                close_frame(STATUS_LONG);
            end else if (stored_cnt == 0) begin
                // kiss control byte, never emitted
                rejected   = (c != cfg_ctrl);
                stored_cnt = LB'(1);
            end else begin
                stored_cnt = stored_cnt + 1'b1;
                if (!rejected) begin
                    r.payload = c;
                    r.is_end  = 1'b0;
                    r.length  = '0;
                    r.status  = STATUS_GOOD;
                    decoded_fifo.push_back(r);
                end
            end
        end
    endtask

    task automatic check_result();
        deframe_result_t want;
        if (decoded_fifo.size() == 0) begin
            $display("%0t: unexpected result: payload %h end %b length %0d status %0d",
                     $time, m_payload_byte, m_frame_end, m_frame_length, m_frame_status);
            error_count++;
        end else begin
            want = decoded_fifo.pop_front();
            if (m_payload_byte !== want.payload || m_frame_end !== want.is_end ||
                m_frame_length !== want.length || m_frame_status !== want.status) begin
                $display("%0t: mismatch: expected payload %h end %b length %0d status %0d",
                         $time, want.payload, want.is_end, want.length, want.status);
                $display("%0t:           actual payload %h end %b length %0d status %0d",
                         $time, m_payload_byte, m_frame_end, m_frame_length, m_frame_status);
                error_count++;
            end
        end
    endtask

    // monitor: transactions on both channels, prediction and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire      <= 1'b0;
            out_fire     <= 1'b0;
            stall_cycles <= 0;
            esc_pending = 1'b0;
            stored_cnt  = '0;
            rejected    = 1'b0;
            skipping    = 1'b0;
        end else begin
            in_fire  <= s_valid && s_ready;
            out_fire <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                deframe_byte(s_rx_byte);
                taken_count++;
            end
            if (m_valid && m_ready)
                check_result();
            stall_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0
                                                                           : stall_cycles + 1;
        end
    end

    // driver: presents queued link bytes with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_rx_byte <= '0;
            send_wait = 0;
        end else if (!s_valid || in_fire) begin
            if (in_fire)
                send_wait = draw_idle(send_idle_on);
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (link_bytes.size() > 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= link_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stall after each taken result
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_fire)
                recv_wait = draw_idle(recv_idle_on);
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_raw(input logic [7:0] b);
        link_bytes.push_back(b);
        queued_count++;
    endtask

    // kiss-encode one data byte, sometimes with a needless escape
    task automatic send_data(input logic [7:0] b);
        if (b == FEND) begin
            send_raw(FESC);
            send_raw(TFEND);
        end else if (b == FESC) begin
            send_raw(FESC);
            send_raw(TFESC);
        end else begin
            if (b != TFEND && b != TFESC && $urandom_range(0, 15) == 0)
                send_raw(FESC);
            send_raw(b);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0: return FEND;
            1: return FESC;
            2: return TFEND;
            3: return TFESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame with random content, lengths up to three past a limit below 40, else up to 30
    task automatic send_frame();
        int top;
        top = (cfg_max_len < 40) ? int'(cfg_max_len) + 3 : 30;
        send_raw(FEND);
        send_data(($urandom_range(0, 3) != 0) ? cfg_ctrl : pick_byte());
        repeat ($urandom_range(0, top)) send_data(pick_byte());
        // an unclosed frame gets ended by the next opening delimiter
        if ($urandom_range(0, 7) != 0)
            send_raw(FEND);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (taken_count != queued_count || decoded_fifo.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CW-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MAX_FRAME_LEN) cfg_max_len = value[LB-1:0];
        else cfg_ctrl = value[7:0];
    endtask

    // chunks of frames and noise; the sender drains fully between chunks
    task automatic random_traffic(input int count);
        int start;
        int chunk_end;
        start = queued_count;
        while (queued_count - start < count) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            chunk_end = queued_count + $urandom_range(20, 80);
            while (queued_count < chunk_end) begin
                if ($urandom_range(0, 6) != 0)
                    send_frame();
                else
                    repeat ($urandom_range(1, 6)) send_raw(pick_byte());
            end
            wait_idle();
        end
    endtask

    // main sequence
    initial begin
        logic [7:0] opening [25];
        opening = '{
            FEND, FEND,
            FEND, 8'h00, 8'hFF, 8'h00, FEND,
            FEND, 8'h00, FESC, TFEND, FESC, TFESC, FESC, 8'h41, FESC, FEND, FEND,
            FEND, 8'h07, 8'h55, FEND,
            FEND, 8'h00, FEND
        };
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: empty, good, escaped, rejected and control-only frames
        foreach (opening[i]) send_raw(opening[i]);
        wait_idle();
        random_traffic(200);

        // one-byte limit, control value 255 written with extra upper bits
        write_reg(CFG_MAX_FRAME_LEN, CW'(1));
        write_reg(CFG_DATA_CONTROL_VALUE, '1);
        send_raw(FEND); send_raw(8'hFF); send_raw(8'hAA);
        send_raw(FESC); send_raw(8'hBB); send_raw(FEND); send_raw(FEND);
        send_raw(FEND); send_raw(8'hFF); send_raw(8'h11);
        send_raw(FESC); send_raw(FEND); send_raw(8'h22); send_raw(FEND);
        wait_idle();
        random_traffic(120);

        // zero limit: even the control byte is too long
        write_reg(CFG_MAX_FRAME_LEN, '0);
        write_reg(CFG_DATA_CONTROL_VALUE, CW'($urandom_range(0, 255)));
        random_traffic(60);

        // full limit, control byte that needs escaping
        write_reg(CFG_MAX_FRAME_LEN, CW'((1 << LB) - 1));
        write_reg(CFG_DATA_CONTROL_VALUE, CW'(FEND));
        random_traffic(120);

        // assorted small limits and control values
        repeat (3) begin
            write_reg(CFG_MAX_FRAME_LEN, CW'($urandom_range(2, 40)));
            write_reg(CFG_DATA_CONTROL_VALUE, CW'($urandom_range(0, (1 << CW) - 1)));
            random_traffic(70);
        end

        wait_idle();
        repeat (8) @(negedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/kfd_pkg.sv
hw/rtl/kiss_frame_deframer_unit.sv
tb/tb_top.sv
